FILE: rtl/core/reversible_deque_buffer_core_assert.svh
// Assertion macros for the deque core. Synthesis builds define SYNTH.
`ifndef REVERSIBLE_DEQUE_BUFFER_CORE_ASSERT_SVH
`define REVERSIBLE_DEQUE_BUFFER_CORE_ASSERT_SVH

`ifndef SYNTH
`define RDB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deque core assertion failed");
`define RDB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deque core assertion failed");
`else
`define RDB_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define RDB_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/core/rdb_pkg.sv
package rdb_pkg;

    localparam int unsigned DEPTH_DEFAULT = 1024;

    typedef enum logic [1:0] {
        OP_TOGGLE = 2'd0,
        OP_ADD    = 2'd1,
        OP_READ   = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef struct packed {
        logic [1:0] opcode;
        logic       at_back;
        logic [7:0] char_in;
        logic [9:0] position;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  char_out;
        logic [1:0]  status;
        logic [10:0] fill_count;
        logic        reversed;
    } out_item_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_req_t;

    // Result of one item as seen by the output stage; the byte comes from the memory.
    typedef struct packed {
        logic        read_hit;
        logic [1:0]  status;
        logic [10:0] fill_count;
        logic        reversed;
    } result_t;

endpackage

FILE: rtl/core/rdb_mem.sv
module rdb_mem #(
    parameter int unsigned DEPTH = rdb_pkg::DEPTH_DEFAULT
) (
    input  logic                     clk,
    input  rdb_pkg::mem_req_t        req,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [7:0]               wdata,
    output logic [7:0]               rdata
);
    import rdb_pkg::*;

    logic [7:0] byte_mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            byte_mem[addr] <= wdata;
        end
    end

    // Hold the last read byte until the next read.
    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rdata_reg <= byte_mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/rdb_ctrl.sv
`include "reversible_deque_buffer_core_assert.svh"

module rdb_ctrl #(
    parameter int unsigned DEPTH = rdb_pkg::DEPTH_DEFAULT
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  rdb_pkg::in_item_t        in_data,
    output logic                     res_valid,
    input  logic                     res_ready,
    output rdb_pkg::result_t         res,
    output rdb_pkg::mem_req_t        mem_req,
    output logic [$clog2(DEPTH)-1:0] mem_addr,
    output logic [7:0]               mem_wdata
);
    import rdb_pkg::*;

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam int unsigned SUM_W = CNT_W + 1;
    localparam int unsigned CMP_W = (CNT_W > 10) ? CNT_W : 10;

    logic [PTR_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             rev_reg, rev_next;
    logic             valid_reg, valid_next;
    logic             hit_reg, hit_next;
    status_t          status_reg, status_next;

    logic             accept;
    logic             full;
    logic             phys_back;
    logic             in_range;
    logic [PTR_W-1:0] head_dec;
    logic [CNT_W-1:0] rd_offset;
    logic [CNT_W-1:0] offset;
    logic [SUM_W-1:0] ring_sum;
    logic [PTR_W-1:0] ring_addr;

    assign in_ready = !valid_reg || res_ready;
    assign accept   = in_valid && in_ready;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign phys_back = in_data.at_back ^ rev_reg;
    assign in_range  = CMP_W'(in_data.position) < CMP_W'(count_reg);
    assign head_dec  = (head_reg == '0) ? PTR_W'(DEPTH - 1) : head_reg - PTR_W'(1);

    // Count a reversed read from the physical back.
    assign rd_offset = rev_reg
        ? CNT_W'(CMP_W'(count_reg) - CMP_W'(1) - CMP_W'(in_data.position))
        : CNT_W'(in_data.position);

    assign offset    = (in_data.opcode == OP_READ) ? rd_offset : count_reg;
    assign ring_sum  = SUM_W'(head_reg) + SUM_W'(offset);
    assign ring_addr = (ring_sum >= SUM_W'(DEPTH)) ? PTR_W'(ring_sum - SUM_W'(DEPTH))
                                                   : PTR_W'(ring_sum);

    always_comb
    begin
        head_next   = head_reg;
        count_next  = count_reg;
        rev_next    = rev_reg;
        hit_next    = hit_reg;
        status_next = status_reg;
        mem_req     = '0;
        mem_addr    = ring_addr;
        mem_wdata   = in_data.char_in;
        valid_next  = valid_reg;
        if (res_ready)
        begin
            valid_next = 1'b0;
        end
        if (accept)
        begin
            valid_next  = 1'b1;
            hit_next    = 1'b0;
            status_next = ST_OK;
            case (in_data.opcode)
                OP_TOGGLE:
                begin
                    rev_next = !rev_reg;
                end
                OP_ADD:
                begin
                    if (full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        mem_req.wr_en = 1'b1;
                        count_next    = count_reg + CNT_W'(1);
                        if (!phys_back)
                        begin
                            mem_addr  = head_dec;
                            head_next = head_dec;
                        end
                    end
                end
                OP_READ:
                begin
                    if (in_range)
                    begin
                        mem_req.rd_en = 1'b1;
                        hit_next      = 1'b1;
                    end
                    else
                    begin
                        status_next = ST_RANGE;
                    end
                end
                default:
                begin
                    status_next = ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            count_reg  <= '0;
            rev_reg    <= 1'b0;
            valid_reg  <= 1'b0;
            hit_reg    <= 1'b0;
            status_reg <= ST_OK;
        end
        else
        begin
            head_reg   <= head_next;
            count_reg  <= count_next;
            rev_reg    <= rev_next;
            valid_reg  <= valid_next;
            hit_reg    <= hit_next;
            status_reg <= status_next;
        end
    end

    assign res_valid      = valid_reg;
    assign res.read_hit   = hit_reg;
    assign res.status     = status_reg;
    assign res.fill_count = 11'(count_reg);
    assign res.reversed   = rev_reg;

    `RDB_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(DEPTH))
    `RDB_ASSERT_NOW(a_one_access, clk, rst_n, 1'b1, !(mem_req.wr_en && mem_req.rd_en))
    `RDB_ASSERT_NEXT(a_toggle_flips, clk, rst_n, accept && in_data.opcode == OP_TOGGLE,
        rev_reg != $past(rev_reg))
    `RDB_ASSERT_NEXT(a_full_drop, clk, rst_n, accept && in_data.opcode == OP_ADD && full,
        count_reg == $past(count_reg) && head_reg == $past(head_reg))

endmodule

FILE: rtl/core/reversible_deque_buffer_core.sv
// Reversible byte deque held in a ring buffer.
// Input channel in_valid/in_ready/in_data carries one operation per item:
// toggle the reversal flag, add a byte at the logical front or back, or read
// the byte at a logical position. Output channel out_valid/out_ready/out_data
// returns exactly one result item per input item: the byte read, a status
// (ok, push dropped because full, read out of range), the fill count and the
// reversal flag after the operation.
// The result is shown in the cycle after the item is accepted, with a read
// byte taken from the registered memory port. Throughput is one item per
// cycle unless the receiver stalls; the single-port byte memory sees at most
// one access per item, and a write always lands before the next item's read.
// When the receiver stalls, the result holds and in_ready drops until it is
// taken; an item is still accepted in the cycle the pending result leaves.
// Reset empties the deque, clears the reversal flag and drops any pending
// result. No clearing pass: reads only reach entries already written.
module reversible_deque_buffer_core #(
    parameter int unsigned DEPTH = rdb_pkg::DEPTH_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  rdb_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output rdb_pkg::out_item_t out_data
);
    import rdb_pkg::*;

    result_t                  res;
    mem_req_t                 mem_req;
    logic [$clog2(DEPTH)-1:0] mem_addr;
    logic [7:0]               mem_wdata;
    logic [7:0]               mem_rdata;

    rdb_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .res_valid (out_valid),
        .res_ready (out_ready),
        .res       (res),
        .mem_req   (mem_req),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata)
    );

    rdb_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .clk   (clk),
        .req   (mem_req),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // Drop the stale memory byte unless this item was a valid read.
    assign out_data.char_out   = res.read_hit ? mem_rdata : 8'd0;
    assign out_data.status     = res.status;
    assign out_data.fill_count = res.fill_count;
    assign out_data.reversed   = res.reversed;

endmodule
